FILE: design/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, widths and latencies of the ray / triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int IDX_W        = 10;
  localparam int MODE_W       = 2;
  localparam int IN_TDATA_W   = 224;
  localparam int OUT_TDATA_W  = 176;

  localparam int DET_W        = 102;
  localparam int NUM_W        = DET_W + 16;
  localparam int T_QW         = 31;
  localparam int N_QW         = 15;

  localparam int DET_LAT      = 8;
  localparam int DIV_LAT      = T_QW + 1;
  localparam int SQ_LAT       = 32;
  localparam int NDIV_LAT     = N_QW + 1;

  localparam int REG_EPS_T    = 0;
  localparam logic [15:0] EPS_RESET = 16'd7;
  localparam int W_ONE        = 65536;
  localparam int NORM_ONE     = 16384;

  typedef enum logic [MODE_W-1:0] {
    MODE_VERT = 2'd0,
    MODE_NORM = 2'd1,
    MODE_TEST = 2'd2
  } mode_t;

  typedef logic signed [31:0] crd_t;
  typedef logic signed [15:0] nco_t;

  typedef struct packed {
    crd_t x;
    crd_t y;
    crd_t z;
  } vec_t;

  typedef struct packed {
    nco_t x;
    nco_t y;
    nco_t z;
  } nrm_t;

endpackage

FILE: design/rti_ram.sv
// ----------------------------------------------------------------------------
// rti_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rti_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/rti_dly.sv
// ----------------------------------------------------------------------------
// rti_dly
// Stallable delay line that carries side data beside a pipelined unit.
// ----------------------------------------------------------------------------
module rti_dly #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) tap_r[i] <= '0;
    end else if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[N-1];

endmodule

FILE: design/rti_det.sv
// ----------------------------------------------------------------------------
// rti_det
// Eight stage pipeline for the four Cramer determinants, sign fix and
// miss tests; hands positive denominator and scaled numerators onward.
// ----------------------------------------------------------------------------
module rti_det import rti_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  vec_t             pa,
  input  vec_t             pb,
  input  vec_t             pc,
  input  vec_t             org,
  input  vec_t             dir,
  output logic [DET_W-1:0] den,
  output logic [NUM_W-1:0] num_t,
  output logic [NUM_W-1:0] num_b,
  output logic [NUM_W-1:0] num_c,
  output logic             miss
);

  localparam int PW = 101;
  localparam int P2A [12] = '{5, 6, 7, 6, 5, 7, 6, 4, 4, 5, 4, 7};
  localparam int P2B [12] = '{10, 9, 10, 11, 11, 9, 8, 10, 9, 8, 11, 8};
  localparam int PC  [12] = '{0, 1, 2, 3, 1, 2, 0, 3, 2, 0, 1, 3};
  localparam int PM  [12] = '{0, 3, 4, 0, 1, 2, 1, 3, 5, 2, 5, 4};
  localparam logic [11:0] PNEG = 12'b010_000_110_000;

  function automatic logic signed [32:0] sx(input crd_t v);
    return {v[31], v};
  endfunction

  logic signed [32:0]      d1_nxt [12];
  logic signed [32:0]      d1_r   [12];
  logic signed [65:0]      p2_nxt [12];
  logic signed [65:0]      p2_r   [12];
  logic signed [32:0]      c2_r   [4];
  logic signed [66:0]      mn_nxt [6];
  logic signed [66:0]      mn_r   [6];
  logic signed [32:0]      c3_r   [4];
  logic signed [67:0]      lo_nxt [12];
  logic signed [67:0]      lo_r   [12];
  logic signed [65:0]      hi_nxt [12];
  logic signed [65:0]      hi_r   [12];
  logic signed [PW-1:0]    pr_nxt [12];
  logic signed [PW-1:0]    pr_r   [12];
  logic signed [DET_W-1:0] dt_nxt [4];
  logic signed [DET_W-1:0] dt_r   [4];
  logic signed [DET_W-1:0] ds_nxt [4];
  logic signed [DET_W-1:0] ds_r   [4];
  logic signed [DET_W+1:0] slack;
  logic                    miss_nxt;
  logic [DET_W-1:0]        den_r;
  logic [NUM_W-1:0]        nt_r, nb_r, nc_r;
  logic                    miss_r;

  always_comb begin
    d1_nxt[0]  = sx(pa.x) - sx(pb.x);
    d1_nxt[1]  = sx(pa.x) - sx(pc.x);
    d1_nxt[2]  = sx(dir.x);
    d1_nxt[3]  = sx(pa.x) - sx(org.x);
    d1_nxt[4]  = sx(pa.y) - sx(pb.y);
    d1_nxt[5]  = sx(pa.y) - sx(pc.y);
    d1_nxt[6]  = sx(dir.y);
    d1_nxt[7]  = sx(pa.y) - sx(org.y);
    d1_nxt[8]  = sx(pa.z) - sx(pb.z);
    d1_nxt[9]  = sx(pa.z) - sx(pc.z);
    d1_nxt[10] = sx(dir.z);
    d1_nxt[11] = sx(pa.z) - sx(org.z);
    for (int i = 0; i < 12; i++) p2_nxt[i] = d1_r[P2A[i]] * d1_r[P2B[i]];
    for (int i = 0; i < 6; i++) mn_nxt[i] = p2_r[2*i] - p2_r[2*i+1];
    for (int i = 0; i < 12; i++) begin
      lo_nxt[i] = c3_r[PC[i]] * $signed({1'b0, mn_r[PM[i]][33:0]});
      hi_nxt[i] = c3_r[PC[i]] * $signed(mn_r[PM[i]][66:34]);
    end
    for (int i = 0; i < 12; i++) begin
      pr_nxt[i] = (PW'(hi_r[i]) <<< 34) + PW'(lo_r[i]);
      if (PNEG[i]) pr_nxt[i] = -pr_nxt[i];
    end
    for (int g = 0; g < 4; g++) begin
      dt_nxt[g] = DET_W'(pr_r[3*g]) + DET_W'(pr_r[3*g+1]) + DET_W'(pr_r[3*g+2]);
    end
    for (int g = 0; g < 4; g++) ds_nxt[g] = dt_r[0][DET_W-1] ? -dt_r[g] : dt_r[g];
    slack    = (DET_W+2)'(ds_r[0]) - (DET_W+2)'(ds_r[1]) - (DET_W+2)'(ds_r[2]);
    miss_nxt = (ds_r[0] == '0) || ds_r[1][DET_W-1] || ds_r[2][DET_W-1]
            || ds_r[3][DET_W-1] || slack[DET_W+1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= d1_nxt;
      p2_r   <= p2_nxt;
      for (int i = 0; i < 4; i++) c2_r[i] <= d1_r[i];
      mn_r   <= mn_nxt;
      c3_r   <= c2_r;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      pr_r   <= pr_nxt;
      dt_r   <= dt_nxt;
      ds_r   <= ds_nxt;
      den_r  <= ds_r[0];
      nb_r   <= {ds_r[1], 16'd0};
      nc_r   <= {ds_r[2], 16'd0};
      nt_r   <= {ds_r[3], 16'd0};
      miss_r <= miss_nxt;
    end
  end

  assign den   = den_r;
  assign num_t = nt_r;
  assign num_b = nb_r;
  assign num_c = nc_r;
  assign miss  = miss_r;

endmodule

FILE: design/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, one quotient bit per stage, saturating
// to all ones when the quotient does not fit.
// ----------------------------------------------------------------------------
module rti_div #(
  parameter int NW = 118,
  parameter int DW = 102,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int W = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [W-1:0]  rem_r [QW+1];
  logic [W-1:0]  dv_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          sat_r [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= W'(num);
      dv_r[0]  <= W'(den);
      q_r[0]   <= '0;
      sat_r[0] <= W'(num) >= (W'(den) << QW);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [W-1:0] trial;
    logic         take;
    assign take  = rem_r[k-1] >= (dv_r[k-1] << (QW - k));
    assign trial = rem_r[k-1] - (dv_r[k-1] << (QW - k));
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? trial : rem_r[k-1];
        dv_r[k]  <= dv_r[k-1];
        q_r[k]   <= q_r[k-1] | (take ? (QW'(1) << (QW - k)) : '0);
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  assign quo = sat_r[QW] ? '1 : q_r[QW];

endmodule

FILE: design/rti_sqrt.sv
// ----------------------------------------------------------------------------
// rti_sqrt
// Pipelined integer square root of a 64 bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module rti_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] sq,
  output logic [31:0] root
);

  logic [63:0] s_r [32];
  logic [63:0] r_r [32];

  for (genvar i = 0; i < 32; i++) begin : g_stage
    localparam logic [63:0] B = 64'd1 << (62 - 2*i);
    logic [63:0] s_in, r_in;
    logic        take;
    if (i == 0) begin : g_first
      assign s_in = sq;
      assign r_in = '0;
    end else begin : g_next
      assign s_in = s_r[i-1];
      assign r_in = r_r[i-1];
    end
    assign take = s_in >= r_in + B;
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i] <= take ? s_in - (r_in + B) : s_in;
        r_r[i] <= take ? (r_in >> 1) + B : r_in >> 1;
      end
    end
  end

  assign root = r_r[31][31:0];

endmodule

FILE: design/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Vertex and normal stores plus a fully pipelined Cramer's rule ray / triangle
// test with hit point and interpolated unit normal.
//
//   channel | dir | handshake           | payload
//   in_     | in  | tvalid/tready       | tuser mode, tdata indices, origin, dir
//   out_    | out | tvalid/tready       | tuser hit, tdata t, normal, hit point
//   cfg_    | in  | apb, pready high    | eps_t at byte address 0
//
// One transaction per cycle unless out_tready stalls; a test's result passes
// through 94 register stages: store read 1, determinants 8,
// divide 32, shading 4, square root 32, normal divide 16, output register 1.
// Writes give no result.
// A stall on out_tready holds the whole pipeline; in_tready follows it and is
// low in reset.
// Reset clears valid bits and loads eps_t with 7; store contents are undefined
// until written.
// ----------------------------------------------------------------------------
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int VERTEX_COUNT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // mode
  input  logic [MODE_W-1:0]      in_tuser,
  // idx_a, idx_b, idx_c, org_x, org_y, org_z, dir_x, dir_y, dir_z, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // hit
  output logic                   out_tuser,
  // t_hit, norm_x, norm_y, norm_z, pos_x, pos_y, pos_z, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int DEPTH = (VERTEX_COUNT < (1 << IDX_W)) ? VERTEX_COUNT : (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
  localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

  function automatic crd_t vc(input vec_t v, input int k);
    case (k)
      0:       return v.x;
      1:       return v.y;
      default: return v.z;
    endcase
  endfunction

  function automatic nco_t nc(input nrm_t v, input int k);
    case (k)
      0:       return v.x;
      1:       return v.y;
      default: return v.z;
    endcase
  endfunction

  // config
  logic [15:0] eps_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == 1'(REG_EPS_T)) ? {16'd0, eps_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_wr && cfg_paddr[2] == 1'(REG_EPS_T)) begin
      eps_r <= cfg_pwdata[15:0];
    end
  end

  // input and stores
  logic             en, acc;
  mode_t            mode;
  logic [IDX_W-1:0] idx [3];
  vec_t             in_org, in_dir;
  logic             we_v, we_n;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en && rst_n;
  assign acc       = in_tvalid && in_tready;
  assign mode      = mode_t'(in_tuser);
  assign idx[0]    = in_tdata[9:0];
  assign idx[1]    = in_tdata[19:10];
  assign idx[2]    = in_tdata[29:20];
  assign in_org    = '{x: in_tdata[61:30], y: in_tdata[93:62], z: in_tdata[125:94]};
  assign in_dir    = '{x: in_tdata[157:126], y: in_tdata[189:158], z: in_tdata[221:190]};
  assign we_v      = acc && mode == MODE_VERT && 32'(idx[0]) < VERTEX_COUNT;
  assign we_n      = acc && mode == MODE_NORM && 32'(idx[0]) < VERTEX_COUNT;

  logic [31:0] rx [3];
  logic [31:0] ry [3];
  logic [31:0] rz [3];
  logic [47:0] rn [3];

  for (genvar p = 0; p < 3; p++) begin : g_port
    rti_ram #(.W(32), .DEPTH(DEPTH)) u_ram_x (
      .clk(clk), .we(we_v), .waddr(idx[0][AW-1:0]), .wdata(in_org.x),
      .re(en), .raddr(idx[p][AW-1:0]), .rdata(rx[p])
    );
    rti_ram #(.W(32), .DEPTH(DEPTH)) u_ram_y (
      .clk(clk), .we(we_v), .waddr(idx[0][AW-1:0]), .wdata(in_org.y),
      .re(en), .raddr(idx[p][AW-1:0]), .rdata(ry[p])
    );
    rti_ram #(.W(32), .DEPTH(DEPTH)) u_ram_z (
      .clk(clk), .we(we_v), .waddr(idx[0][AW-1:0]), .wdata(in_org.z),
      .re(en), .raddr(idx[p][AW-1:0]), .rdata(rz[p])
    );
    rti_ram #(.W(48), .DEPTH(DEPTH)) u_ram_n (
      .clk(clk), .we(we_n), .waddr(idx[0][AW-1:0]),
      .wdata({in_org.z[15:0], in_org.y[15:0], in_org.x[15:0]}),
      .re(en), .raddr(idx[p][AW-1:0]), .rdata(rn[p])
    );
  end

  logic       f_vld_r;
  logic [2:0] f_oob_r;
  vec_t       f_org_r, f_dir_r;
  vec_t       fp [3];
  nrm_t       fn [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= acc && mode == MODE_TEST;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) f_oob_r[p] <= 32'(idx[p]) >= VERTEX_COUNT;
      f_org_r <= in_org;
      f_dir_r <= in_dir;
    end
  end

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      fp[p] = f_oob_r[p] ? '0 : vec_t'({rx[p], ry[p], rz[p]});
      fn[p] = f_oob_r[p] ? '0 : nrm_t'({rn[p][15:0], rn[p][31:16], rn[p][47:32]});
    end
  end

  // determinants and divides
  logic [DET_W-1:0] den;
  logic [NUM_W-1:0] num_t, num_b, num_c;
  logic             miss, miss_d;
  logic [T_QW-1:0]  tq, qb, qc;

  rti_det u_det (
    .clk(clk), .en(en), .pa(fp[0]), .pb(fp[1]), .pc(fp[2]),
    .org(f_org_r), .dir(f_dir_r),
    .den(den), .num_t(num_t), .num_b(num_b), .num_c(num_c), .miss(miss)
  );

  rti_div #(.NW(NUM_W), .DW(DET_W), .QW(T_QW)) u_div_t (
    .clk(clk), .en(en), .num(num_t), .den(den), .quo(tq)
  );
  rti_div #(.NW(NUM_W), .DW(DET_W), .QW(T_QW)) u_div_b (
    .clk(clk), .en(en), .num(num_b), .den(den), .quo(qb)
  );
  rti_div #(.NW(NUM_W), .DW(DET_W), .QW(T_QW)) u_div_c (
    .clk(clk), .en(en), .num(num_c), .den(den), .quo(qc)
  );

  rti_dly #(.W(1), .N(DIV_LAT)) u_dly_miss (
    .clk(clk), .rst_n(rst_n), .en(en), .d(miss), .q(miss_d)
  );

  localparam int D1_W = 1 + 3*32 + 3*32 + 3*48;
  logic [D1_W-1:0] d1_q;
  logic            v1;
  vec_t            o1, r1;
  nrm_t            na1, nb1, nc1;

  rti_dly #(.W(D1_W), .N(DET_LAT + DIV_LAT)) u_dly_ray (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({f_vld_r, f_org_r, f_dir_r, fn[0], fn[1], fn[2]}), .q(d1_q)
  );
  assign {v1, o1, r1, na1, nb1, nc1} = d1_q;

  // shading
  logic [17:0] wa_full;
  logic [16:0] wgt [3];
  logic        hit1;

  assign hit1    = v1 && !miss_d && tq >= T_QW'(eps_r);
  assign wa_full = 18'(W_ONE) - {1'b0, qb[16:0]} - {1'b0, qc[16:0]};
  assign wgt[0]  = wa_full[16:0];
  assign wgt[1]  = qb[16:0];
  assign wgt[2]  = qc[16:0];

  logic               n1_vld_r, n1_hit_r;
  logic [T_QW-1:0]    n1_tq_r;
  vec_t               n1_org_r;
  logic signed [63:0] n1_pp_r [3];
  logic signed [33:0] n1_wp_r [9];

  logic               n2_vld_r, n2_hit_r;
  logic [T_QW-1:0]    n2_tq_r;
  crd_t               n2_pos_r [3];
  logic signed [35:0] n2_ws_r [3];

  logic               n3_vld_r, n3_hit_r;
  logic [T_QW-1:0]    n3_tq_r;
  crd_t               n3_pos_r [3];
  logic [31:0]        n3_mag_r [3];
  logic [2:0]         n3_sgn_r;
  logic [63:0]        n3_sq_r [3];

  logic               n4_vld_r, n4_hit_r;
  logic [T_QW-1:0]    n4_tq_r;
  crd_t               n4_pos_r [3];
  logic [31:0]        n4_mag_r [3];
  logic [2:0]         n4_sgn_r;
  logic [63:0]        n4_ss_r;

  logic signed [48:0] psum [3];
  crd_t               pos_nxt [3];

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      psum[x] = 49'(vc(n1_org_r, x)) + 49'(n1_pp_r[x] >>> 16);
      if (psum[x] > SAT_HI) begin
        pos_nxt[x] = 32'sh7fffffff;
      end else if (psum[x] < SAT_LO) begin
        pos_nxt[x] = 32'sh80000000;
      end else begin
        pos_nxt[x] = psum[x][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_vld_r <= 1'b0;
      n2_vld_r <= 1'b0;
      n3_vld_r <= 1'b0;
      n4_vld_r <= 1'b0;
    end else if (en) begin
      n1_vld_r <= v1;
      n2_vld_r <= n1_vld_r;
      n3_vld_r <= n2_vld_r;
      n4_vld_r <= n3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_hit_r <= hit1;
      n1_tq_r  <= tq;
      n1_org_r <= o1;
      for (int x = 0; x < 3; x++) begin
        n1_pp_r[x]     <= $signed({1'b0, tq}) * vc(r1, x);
        n1_wp_r[3*x]   <= $signed({1'b0, wgt[0]}) * nc(na1, x);
        n1_wp_r[3*x+1] <= $signed({1'b0, wgt[1]}) * nc(nb1, x);
        n1_wp_r[3*x+2] <= $signed({1'b0, wgt[2]}) * nc(nc1, x);
      end
      n2_hit_r <= n1_hit_r;
      n2_tq_r  <= n1_tq_r;
      for (int x = 0; x < 3; x++) begin
        n2_pos_r[x] <= pos_nxt[x];
        n2_ws_r[x]  <= 36'(n1_wp_r[3*x]) + 36'(n1_wp_r[3*x+1]) + 36'(n1_wp_r[3*x+2]);
      end
      n3_hit_r <= n2_hit_r;
      n3_tq_r  <= n2_tq_r;
      n3_pos_r <= n2_pos_r;
      for (int x = 0; x < 3; x++) begin
        n3_sgn_r[x] <= n2_ws_r[x][35];
        n3_mag_r[x] <= n2_ws_r[x][35] ? 32'(-n2_ws_r[x]) : 32'(n2_ws_r[x]);
        n3_sq_r[x]  <= n2_ws_r[x][35] ? 64'(32'(-n2_ws_r[x])) * 64'(32'(-n2_ws_r[x]))
                                      : 64'(32'(n2_ws_r[x])) * 64'(32'(n2_ws_r[x]));
      end
      n4_hit_r <= n3_hit_r;
      n4_tq_r  <= n3_tq_r;
      n4_pos_r <= n3_pos_r;
      n4_mag_r <= n3_mag_r;
      n4_sgn_r <= n3_sgn_r;
      n4_ss_r  <= n3_sq_r[0] + n3_sq_r[1] + n3_sq_r[2];
    end
  end

  // normal length and normalize
  logic [31:0] len;

  rti_sqrt u_sqrt (.clk(clk), .en(en), .sq(n4_ss_r), .root(len));

  localparam int D2_W = 2 + T_QW + 96 + 96 + 3;
  logic [D2_W-1:0] d2_q;
  logic            v2, h2;
  logic [T_QW-1:0] t2;
  logic [95:0]     p2, m2;
  logic [2:0]      s2;

  rti_dly #(.W(D2_W), .N(SQ_LAT)) u_dly_len (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({n4_vld_r, n4_hit_r, n4_tq_r, n4_pos_r[2], n4_pos_r[1], n4_pos_r[0],
        n4_mag_r[2], n4_mag_r[1], n4_mag_r[0], n4_sgn_r}),
    .q(d2_q)
  );
  assign {v2, h2, t2, p2, m2, s2} = d2_q;

  logic [N_QW-1:0] nq [3];

  for (genvar x = 0; x < 3; x++) begin : g_ndiv
    rti_div #(.NW(46), .DW(32), .QW(N_QW)) u_div_n (
      .clk(clk), .en(en), .num({m2[32*x +: 32], 14'd0}), .den(len), .quo(nq[x])
    );
  end

  localparam int D3_W = 2 + T_QW + 96 + 3 + 1;
  logic [D3_W-1:0] d3_q;
  logic            v3, h3, lz3;
  logic [T_QW-1:0] t3;
  logic [95:0]     p3;
  logic [2:0]      s3;

  rti_dly #(.W(D3_W), .N(NDIV_LAT)) u_dly_nrm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({v2, h2, t2, p2, s2, len == '0}), .q(d3_q)
  );
  assign {v3, h3, t3, p3, s3, lz3} = d3_q;

  // output register
  logic            out_valid_r, out_hit_r;
  logic [T_QW-1:0] out_t_r;
  nco_t            out_n_r [3];
  crd_t            out_p_r [3];
  nco_t            nv [3];

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      nv[x] = (nq[x] > N_QW'(NORM_ONE)) ? 16'(NORM_ONE) : 16'(nq[x]);
      if (lz3) nv[x] = '0;
      if (s3[x]) nv[x] = -nv[x];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= h3;
      out_t_r   <= h3 ? t3 : '0;
      for (int x = 0; x < 3; x++) begin
        out_n_r[x] <= h3 ? nv[x] : '0;
        out_p_r[x] <= h3 ? crd_t'(p3[32*x +: 32]) : '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {1'b0, out_p_r[2], out_p_r[1], out_p_r[0],
                       out_n_r[2], out_n_r[1], out_n_r[0], out_t_r};

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss result carries nonzero fields");

  a_eps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[30:0] >= T_QW'(eps_r))
    else $error("hit below eps_t");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_n_r[0] <= 16'(NORM_ONE) && out_n_r[0] >= -16'(NORM_ONE)
                && out_n_r[1] <= 16'(NORM_ONE) && out_n_r[1] >= -16'(NORM_ONE)
                && out_n_r[2] <= 16'(NORM_ONE) && out_n_r[2] >= -16'(NORM_ONE))
    else $error("normal component out of range");

endmodule

FILE: verif/rti_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rti_checker
// Watches the input, result and register ports of ray_triangle_intersect,
// keeps its own copy of the vertex and normal stores and of eps_t, predicts
// the result of every ray test it sees taken, and compares each result taken
// from the block field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rti_checker import rti_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [MODE_W-1:0]      in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   out_tuser,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  input  logic                   cfg_pready,
  output int                     errors,
  output int                     pending
);

  typedef logic signed [159:0] big_t;

  typedef struct {
    logic        hit;
    logic [30:0] t_hit;
    nco_t        nx, ny, nz;
    crd_t        px, py, pz;
  } shade_t;

  crd_t        vx [1024];
  crd_t        vy [1024];
  crd_t        vz [1024];
  nrm_t        nstore [1024];
  logic [15:0] eps_t;
  shade_t      hits_q [$];

  assign pending = hits_q.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [30:0] ratio(input big_t num, input big_t den);
    big_t quo;
    quo = num / den;
    if (quo > big_t'(32'h7fffffff)) return 31'h7fffffff;
    return quo[30:0];
  endfunction

  function automatic longint unsigned root(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic shade_t predict(input logic [9:0] ia, ib, ic, input crd_t org[3],
                                     input crd_t dir[3]);
    shade_t res;
    big_t pa[3], pb[3], pc[3], o[3], dv[3];
    big_t a, b, c, d, e, f, g, h, i, j, k, l, m, n, p, q, s, r1, den, e1, e2, e3;
    nco_t na[3], nb[3], nc[3];
    logic [30:0] tq, wb, wc;
    longint wa, prod, sum;
    longint w[3];
    longint unsigned len, mag, v;
    res = '{default: '0};
    pa = '{vx[ia], vy[ia], vz[ia]};
    pb = '{vx[ib], vy[ib], vz[ib]};
    pc = '{vx[ic], vy[ic], vz[ic]};
    na = '{nstore[ia].x, nstore[ia].y, nstore[ia].z};
    nb = '{nstore[ib].x, nstore[ib].y, nstore[ib].z};
    nc = '{nstore[ic].x, nstore[ic].y, nstore[ic].z};
    for (int x = 0; x < 3; x++) begin
      o[x] = org[x];
      dv[x] = dir[x];
    end
    a = pa[0] - pb[0]; b = pa[0] - pc[0]; c = dv[0]; d = pa[0] - o[0];
    e = pa[1] - pb[1]; f = pa[1] - pc[1]; g = dv[1]; h = pa[1] - o[1];
    i = pa[2] - pb[2]; j = pa[2] - pc[2]; k = dv[2]; l = pa[2] - o[2];
    m = f * k - g * j; n = h * k - g * l; p = f * l - h * j;
    q = g * i - e * k; s = e * j - f * i; r1 = e * l - h * i;
    den = a * m + b * q + c * s;
    e1 = d * m - b * n - c * p;
    e2 = a * n + d * q + c * r1;
    e3 = a * p - b * r1 + d * s;
    if (den == 0) return res;
    if (den < 0) begin
      den = -den; e1 = -e1; e2 = -e2; e3 = -e3;
    end
    if (e1 < 0 || e2 < 0 || den - e1 - e2 < 0) return res;
    if ((e3 <<< 16) - big_t'({144'd0, eps_t}) * den < 0) return res;
    tq = ratio(e3 <<< 16, den);
    wb = ratio(e1 <<< 16, den);
    wc = ratio(e2 <<< 16, den);
    wa = 65536 - longint'(wb) - longint'(wc);
    res.hit = 1'b1;
    res.t_hit = tq;
    len = 0;
    for (int x = 0; x < 3; x++) begin
      prod = longint'(tq) * longint'(dir[x]);
      sum = longint'(org[x]) + (prod >>> 16);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      case (x)
        0: res.px = sum[31:0];
        1: res.py = sum[31:0];
        default: res.pz = sum[31:0];
      endcase
      w[x] = wa * longint'(na[x]) + longint'(wb) * longint'(nb[x])
           + longint'(wc) * longint'(nc[x]);
      mag = (w[x] < 0) ? -w[x] : w[x];
      len += mag * mag;
    end
    len = root(len);
    if (len == 0) return res;
    for (int x = 0; x < 3; x++) begin
      mag = (w[x] < 0) ? -w[x] : w[x];
      v = (mag * 16384) / len;
      if (v > 16384) v = 16384;
      if (w[x] < 0) v = -v;
      case (x)
        0: res.nx = v[15:0];
        1: res.ny = v[15:0];
        default: res.nz = v[15:0];
      endcase
    end
    return res;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    logic [9:0] ia;
    crd_t       org[3], dir[3];
    shade_t     got, want;
    if (!rst_n) begin
      eps_t <= EPS_RESET;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 3'(4 * REG_EPS_T))
        eps_t <= cfg_pwdata[15:0];
      if (in_tvalid && in_tready) begin
        ia = in_tdata[9:0];
        for (int x = 0; x < 3; x++) begin
          org[x] = in_tdata[30 + 32 * x +: 32];
          dir[x] = in_tdata[126 + 32 * x +: 32];
        end
        case (in_tuser)
          MODE_VERT: begin
            vx[ia] = org[0]; vy[ia] = org[1]; vz[ia] = org[2];
          end
          MODE_NORM: nstore[ia] = '{org[0][15:0], org[1][15:0], org[2][15:0]};
          MODE_TEST: hits_q.push_back(predict(ia, in_tdata[19:10], in_tdata[29:20], org, dir));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.hit = out_tuser;
        got.t_hit = out_tdata[30:0];
        got.nx = out_tdata[46:31];
        got.ny = out_tdata[62:47];
        got.nz = out_tdata[78:63];
        got.px = out_tdata[110:79];
        got.py = out_tdata[142:111];
        got.pz = out_tdata[174:143];
        if (hits_q.size() == 0) begin
          report("unexpected transaction hit", got.hit, 0);
        end else begin
          want = hits_q.pop_front();
          if (got.hit != want.hit) report("hit", got.hit, want.hit);
          if (got.t_hit != want.t_hit) report("t_hit", got.t_hit, want.t_hit);
          if (got.nx != want.nx) report("norm_x", got.nx, want.nx);
          if (got.ny != want.ny) report("norm_y", got.ny, want.ny);
          if (got.nz != want.nz) report("norm_z", got.nz, want.nz);
          if (got.px != want.px) report("pos_x", got.px, want.px);
          if (got.py != want.py) report("pos_y", got.py, want.py);
          if (got.pz != want.pz) report("pos_z", got.pz, want.pz);
        end
      end
    end
  end

endmodule

FILE: verif/tb_ray_triangle_intersect.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersect
// Fills the vertex and normal stores, fires directed corner-case rays and then
// random rays aimed into stored triangles plus random noise, under several
// eps_t settings, with random idle bursts on both streams and one long result
// stall. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersect;
  import rti_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int ONE = 65536;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic                   clk, rst_n;
  logic                   in_tvalid, in_tready;
  logic [MODE_W-1:0]      in_tuser;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid, out_tready, out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]             cfg_paddr;
  logic [31:0]            cfg_pwdata, cfg_prdata;
  int                     errors, pending, idle_cycles, sent;
  bit                     quiet;

  crd_t vx [1024];
  crd_t vy [1024];
  crd_t vz [1024];
  bit   has_v [1024];
  int   ready_idx [$];

  ray_triangle_intersect dut (.*);

  rti_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_ray_triangle_intersect: errors");
      $finish;
    end
  end

  // result side: random stall bursts and one long hold once the flow is going
  initial begin
    bit held;
    held = 0;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && sent >= 300) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send(input logic [MODE_W-1:0] mode, input logic [9:0] ia, ib, ic,
                      input crd_t ox, oy, oz, dx, dy, dz);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {2'b00, dz, dy, dx, oz, oy, ox, ic, ib, ia};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic put_vertex(input logic [9:0] idx, input crd_t x, y, z,
                            input nco_t nx, ny, nz);
    send(MODE_VERT, idx, $urandom, $urandom, x, y, z, $urandom, $urandom, $urandom);
    send(MODE_NORM, idx, $urandom, $urandom, {16'($urandom), nx}, {16'($urandom), ny},
         {16'($urandom), nz}, $urandom, $urandom, $urandom);
    vx[idx] = x; vy[idx] = y; vz[idx] = z;
    if (!has_v[idx]) ready_idx.push_back(idx);
    has_v[idx] = 1;
  endtask

  task automatic set_eps(input logic [15:0] value);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (120) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * REG_EPS_T);
    cfg_pwdata <= {16'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // ray through a random point of a stored triangle
  task automatic aimed_test();
    int a, b, c, bw, cw, steps;
    longint px, py, pz;
    crd_t dx, dy, dz;
    a = ready_idx[$urandom_range(0, ready_idx.size() - 1)];
    b = ready_idx[$urandom_range(0, ready_idx.size() - 1)];
    c = ready_idx[$urandom_range(0, ready_idx.size() - 1)];
    bw = $urandom_range(0, 256);
    cw = $urandom_range(0, 256 - bw);
    px = vx[a] + ((longint'(vx[b]) - vx[a]) * bw + (longint'(vx[c]) - vx[a]) * cw) / 256;
    py = vy[a] + ((longint'(vy[b]) - vy[a]) * bw + (longint'(vy[c]) - vy[a]) * cw) / 256;
    pz = vz[a] + ((longint'(vz[b]) - vz[a]) * bw + (longint'(vz[c]) - vz[a]) * cw) / 256;
    dx = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    dy = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    dz = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    steps = $signed($urandom_range(0, 10)) - 1;
    send(MODE_TEST, a, b, c, crd_t'(px - longint'(dx) * steps), crd_t'(py - longint'(dy) * steps),
         crd_t'(pz - longint'(dz) * steps), dx, dy, dz);
  endtask

  task automatic random_item();
    int r;
    logic [9:0] idx;
    crd_t span;
    r = $urandom_range(0, 99);
    idx = $urandom;
    if (r < 12) begin
      span = ($urandom_range(0, 9) == 0) ? 32'h7fffffff : (1 << 22);
      put_vertex(idx, $signed($urandom % span) * ($urandom_range(0, 1) ? 1 : -1),
                 $signed($urandom % span) * ($urandom_range(0, 1) ? 1 : -1),
                 $signed($urandom % span) * ($urandom_range(0, 1) ? 1 : -1),
                 $urandom, $urandom, $urandom);
    end else if (r < 15) begin
      send(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom);
    end else if (r < 27) begin
      send(MODE_TEST, ready_idx[$urandom_range(0, ready_idx.size() - 1)],
           ready_idx[$urandom_range(0, ready_idx.size() - 1)],
           ready_idx[$urandom_range(0, ready_idx.size() - 1)],
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      aimed_test();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    quiet = 0;
    sent = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // right triangle with legs of 4 in z = 0, a copy with zero normals, a full-range triangle
    put_vertex(0, 0, 0, 0, 0, 0, 16384);
    put_vertex(1, 4 * ONE, 0, 0, 16384, 0, 0);
    put_vertex(2, 0, 4 * ONE, 0, 0, 16384, 0);
    put_vertex(3, 0, 0, 0, 0, 0, 0);
    put_vertex(4, 4 * ONE, 0, 0, 0, 0, 0);
    put_vertex(1023, 32'h80000000, 32'h80000000, 0, -32768, 32767, -32768);
    put_vertex(1022, 32'h7fffffff, 32'h80000000, 0, 32767, -32768, 32767);
    put_vertex(1021, 32'h80000000, 32'h7fffffff, 0, -32768, -32768, 32767);
    send(MODE_TEST, 0, 1, 2, ONE, ONE, 5 * ONE, 0, 0, -ONE);              // plain hit
    send(MODE_TEST, 0, 1, 2, 5 * ONE, 5 * ONE, 5 * ONE, 0, 0, -ONE);      // outside
    send(MODE_TEST, 0, 1, 2, ONE, ONE, 5 * ONE, 0, 0, ONE);               // behind origin
    send(MODE_TEST, 0, 0, 2, ONE, ONE, 5 * ONE, 0, 0, -ONE);              // degenerate
    send(MODE_TEST, 0, 1, 2, ONE, ONE, 0, 0, 0, -ONE);                    // t zero
    send(MODE_TEST, 0, 1, 2, ONE, ONE, 3, 0, 0, -ONE);                    // t under eps
    send(MODE_TEST, 0, 1, 2, ONE, ONE, 7, 0, 0, -ONE);                    // t at eps
    send(MODE_TEST, 0, 1, 2, 0, 2 * ONE, 5 * ONE, 0, 0, -ONE);            // on an edge
    send(MODE_TEST, 0, 1, 2, 4 * ONE, 0, 5 * ONE, 0, 0, -ONE);            // at a corner
    send(MODE_TEST, 0, 1, 2, 2 * ONE, 2 * ONE, 5 * ONE, 0, 0, -ONE);      // far edge
    send(MODE_TEST, 3, 4, 3, ONE, 0, 5 * ONE, 0, 0, -ONE);                // degenerate copy
    send(MODE_TEST, 3, 4, 2, 0, 0, 5 * ONE, 0, 0, -ONE);                  // zero blend
    send(MODE_TEST, 0, 1, 2, ONE, ONE, 5 * ONE, 0, 0, 0);                 // no direction
    send(MODE_TEST, 0, 1, 2, ONE, ONE, 5 * ONE, 0, 0, -1);                // t saturates
    send(MODE_TEST, 1023, 1022, 1021, 0, 0, 32'h7fffffff, 0, 0, 32'h80000000);
    send(MODE_TEST, 1023, 1022, 1021, 32'h80000000, 32'h80000000, 32'h80000000,
         32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send(MODE_NONE, 1023, 1023, 1023, -1, -1, -1, -1, -1, -1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: set_eps(16'd0);
        2: set_eps(16'hffff);
        3: set_eps($urandom);
        default: ;
      endcase
      for (int n = 0; n < 275; n++) begin
        if (phase == 3 && n >= 160) quiet = 1;
        random_item();
      end
    end
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("tb_ray_triangle_intersect: clean");
    end else begin
      $display("tb_ray_triangle_intersect: errors");
    end
    $finish;
  end

endmodule
